>>> rtl/fcpa_pkg.sv
// shared types and constants for the fixed cell pool allocator
`timescale 1ns / 1ps

package fcpa_pkg;

    // pool geometry
    localparam int NUM_CELLS_DEF = 64;
    localparam int OFFSET_W      = 18;
    localparam int COUNT_W       = 7;
    localparam int SIZE_W        = 13;

    // reset values of the configuration registers
    localparam logic [COUNT_W-1:0] CELL_COUNT_RST = 7'd64;
    localparam logic [SIZE_W-1:0]  CELL_SIZE_RST  = 13'd4;

    // configuration register indexes
    localparam logic CFG_CELL_COUNT = 1'b0;
    localparam logic CFG_CELL_SIZE  = 1'b1;

    // item kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_BAD    = 2'd2,
        STAT_DOUBLE = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_CHECK,
        ST_COUNT,
        ST_DONE
    } state_t;

    // request item
    typedef struct packed {
        logic                kind;
        logic [OFFSET_W-1:0] offset;
    } req_t;

    // result item
    typedef struct packed {
        logic [OFFSET_W-1:0] cell_offset;
        status_t             status;
        logic [COUNT_W-1:0]  free_count;
    } rsp_t;

endpackage

>>> rtl/fixed_cell_pool_allocator.sv
// fixed cell pool allocator: free bitmap, sequencer and shared add/subtract unit
`timescale 1ns / 1ps

// Usage: a request item on in_data (kind, offset) is taken when in_valid and
// in_ready are high. kind 0 allocates the lowest free cell and returns its
// byte offset; kind 1 frees the cell at offset. One result item per request
// comes out on out_data under out_valid/out_ready, with status and the count
// of free cells after the request.
// Registers are written on the cfg channel (cfg_index 0 cell_count,
// 1 cell_size); cfg_ready is always high.
// One adder/subtractor is shared by the 18-step restoring divide of a free
// and the offset accumulation of the allocate scan; a count pass over the
// clamped cell count, one cell per cycle, then gives the free count.
// One request is in work at a time; in_ready is low while it is processed.
// The finished result sits in an output register, so a new request can be
// taken while the receiver stalls; the next result waits until it is taken.
// Reset marks every cell free, sets cell_count to 64 and cell_size to 4.
module fixed_cell_pool_allocator #(
    parameter int NUM_CELLS = fcpa_pkg::NUM_CELLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fcpa_pkg::req_t                in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fcpa_pkg::rsp_t                out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [fcpa_pkg::SIZE_W-1:0]   cfg_data
);

    localparam int IDX_W  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int CNT_W  = $clog2(NUM_CELLS + 1);
    localparam int OFF_W  = fcpa_pkg::OFFSET_W;
    localparam int SZ_W   = fcpa_pkg::SIZE_W;
    localparam int ALU_W  = OFF_W + 1;
    localparam int STEP_W = $clog2(OFF_W);

    fcpa_pkg::state_t        state_reg, state_next;
    logic [NUM_CELLS-1:0]    map_reg, map_next;
    logic [CNT_W-1:0]        i_reg, i_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [OFF_W-1:0]        acc_reg, acc_next;
    logic [OFF_W-1:0]        dvd_reg, dvd_next;
    logic [SZ_W-1:0]         rem_reg, rem_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    fcpa_pkg::status_t       status_reg, status_next;
    logic [OFF_W-1:0]        res_off_reg, res_off_next;
    logic                    out_valid_reg, out_valid_next;
    fcpa_pkg::rsp_t          out_data_reg, out_data_next;
    logic [fcpa_pkg::COUNT_W-1:0] cell_count_reg;
    logic [SZ_W-1:0]         cell_size_reg;

    logic [CNT_W-1:0]        n_eff;
    logic [SZ_W-1:0]         size_eff;
    logic [ALU_W-1:0]        alu_a, alu_b, alu_y;
    logic                    alu_sub;
    logic [SZ_W:0]           r_sh;
    logic                    div_ge;
    logic                    cur_bit;

    // effective pool size and cell size
    always_comb
    begin
        if (int'(cell_count_reg) > NUM_CELLS)
            n_eff = CNT_W'(NUM_CELLS);
        else
            n_eff = CNT_W'(cell_count_reg);
        size_eff = (cell_size_reg == '0) ? SZ_W'(1) : cell_size_reg;
    end

    // shared add/subtract unit
    assign r_sh   = {rem_reg, dvd_reg[OFF_W-1]};
    assign alu_sub = (state_reg == fcpa_pkg::ST_DIV);
    assign alu_a  = alu_sub ? ALU_W'(r_sh) : ALU_W'(acc_reg);
    assign alu_b  = ALU_W'(size_eff);
    assign alu_y  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign div_ge = ~alu_y[ALU_W-1];

    // bitmap bit under the scan pointer
    assign cur_bit = map_reg[i_reg[IDX_W-1:0]];

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        map_next       = map_reg;
        i_next         = i_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        status_next    = status_reg;
        res_off_next   = res_off_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            fcpa_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                i_next       = '0;
                cnt_next     = '0;
                acc_next     = '0;
                rem_next     = '0;
                step_next    = '0;
                res_off_next = '0;
                dvd_next     = in_data.offset;
                status_next  = fcpa_pkg::STAT_OK;
                if (in_valid)
                begin
                    if (in_data.kind == fcpa_pkg::KIND_ALLOC)
                        state_next = fcpa_pkg::ST_SCAN;
                    else
                        state_next = fcpa_pkg::ST_DIV;
                end
            end
            // lowest free cell, offset accumulated one cell size per step
            fcpa_pkg::ST_SCAN:
            begin
                if (i_reg == n_eff)
                begin
                    status_next = fcpa_pkg::STAT_FULL;
                    i_next      = '0;
                    state_next  = fcpa_pkg::ST_COUNT;
                end
                else if (cur_bit)
                begin
                    map_next[i_reg[IDX_W-1:0]] = 1'b0;
                    res_off_next = acc_reg;
                    status_next  = fcpa_pkg::STAT_OK;
                    i_next       = '0;
                    state_next   = fcpa_pkg::ST_COUNT;
                end
                else
                begin
                    i_next   = i_reg + CNT_W'(1);
                    acc_next = alu_y[OFF_W-1:0];
                end
            end
            // restoring divide of the offset, one quotient bit per cycle
            fcpa_pkg::ST_DIV:
            begin
                rem_next  = div_ge ? alu_y[SZ_W-1:0] : r_sh[SZ_W-1:0];
                dvd_next  = {dvd_reg[OFF_W-2:0], div_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(OFF_W - 1))
                    state_next = fcpa_pkg::ST_CHECK;
            end
            // validate the cell index and release it if it is valid and in use
            fcpa_pkg::ST_CHECK:
            begin
                if (rem_reg != '0 || dvd_reg >= OFF_W'(n_eff))
                    status_next = fcpa_pkg::STAT_BAD;
                else if (map_reg[dvd_reg[IDX_W-1:0]])
                    status_next = fcpa_pkg::STAT_DOUBLE;
                else
                begin
                    map_next[dvd_reg[IDX_W-1:0]] = 1'b1;
                    status_next = fcpa_pkg::STAT_OK;
                end
                i_next     = '0;
                state_next = fcpa_pkg::ST_COUNT;
            end
            // count free cells one per cycle
            fcpa_pkg::ST_COUNT:
            begin
                if (i_reg == n_eff)
                    state_next = fcpa_pkg::ST_DONE;
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(cur_bit);
                    i_next   = i_reg + CNT_W'(1);
                end
            end
            // hand the item to the output register once it is free
            fcpa_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.cell_offset = res_off_reg;
                    out_data_next.status      = status_reg;
                    out_data_next.free_count  = fcpa_pkg::COUNT_W'(cnt_reg);
                    state_next                = fcpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fcpa_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcpa_pkg::ST_IDLE;
            map_reg       <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            map_reg       <= map_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        cnt_reg      <= cnt_next;
        acc_reg      <= acc_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        status_reg   <= status_next;
        res_off_reg  <= res_off_next;
        out_data_reg <= out_data_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_count_reg <= fcpa_pkg::CELL_COUNT_RST;
            cell_size_reg  <= fcpa_pkg::CELL_SIZE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fcpa_pkg::CFG_CELL_COUNT: cell_count_reg <= cfg_data[fcpa_pkg::COUNT_W-1:0];
                fcpa_pkg::CFG_CELL_SIZE:  cell_size_reg  <= cfg_data;
                default:                  cell_size_reg  <= cell_size_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a full pool never reports an offset
    a_full_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == fcpa_pkg::STAT_FULL |-> out_data.cell_offset == '0)
        else $error("full result with nonzero offset");

    // free count never exceeds the pool size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(out_data.free_count) <= int'(n_eff))
        else $error("free count above pool size");

    // one request at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // a freed cell always carries a zero offset
    a_free_offset: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fcpa_pkg::ST_CHECK |=> res_off_reg == '0)
        else $error("free request produced an offset");

endmodule

>>> verif/tb_fixed_cell_pool_allocator.sv
// testbench for the fixed cell pool allocator: bitmap predictor and result checks
`timescale 1ns / 1ps

module tb_fixed_cell_pool_allocator;

    localparam int POOL_CELLS     = fcpa_pkg::NUM_CELLS_DEF;
    localparam int OFF_W          = fcpa_pkg::OFFSET_W;
    localparam int CNT_W          = fcpa_pkg::COUNT_W;
    localparam int SZ_W           = fcpa_pkg::SIZE_W;
    localparam int OFFSET_MAX     = (1 << OFF_W) - 1;
    localparam int QUIET_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 160;
    localparam int HOLDOFF_CYCLES = 400;

    // tracks the free bitmap and configuration, holds expected results in order
    class pool_scoreboard;
        logic [POOL_CELLS-1:0] free_map;
        int unsigned           cell_count;
        int unsigned           cell_size;
        fcpa_pkg::rsp_t        owed_results[$];
        int                    error_count;

        function new();
            free_map    = '1;
            cell_count  = 32'(fcpa_pkg::CELL_COUNT_RST);
            cell_size   = 32'(fcpa_pkg::CELL_SIZE_RST);
            error_count = 0;
        endfunction

        // counts above the pool size act as the pool size
        function int unsigned active_cells();
            return (cell_count > POOL_CELLS) ? POOL_CELLS : cell_count;
        endfunction

        // a zero cell size acts as one byte
        function int unsigned eff_size();
            return (cell_size == 0) ? 1 : cell_size;
        endfunction

        // byte offset of a cell, cut to the offset width
        function logic [OFF_W-1:0] byte_offset(int unsigned idx);
            longint unsigned prod;
            prod = longint'(idx) * longint'(eff_size());
            return prod[OFF_W-1:0];
        endfunction

        function void apply_register(logic index, logic [SZ_W-1:0] value);
            if (index == fcpa_pkg::CFG_CELL_COUNT)
                cell_count = 32'(value[CNT_W-1:0]);
            else
                cell_size = 32'(value);
        endfunction

        // work out the result of one request and update the bitmap
        function void note_request(fcpa_pkg::req_t req);
            fcpa_pkg::rsp_t exp_rsp;
            int unsigned    n;
            int unsigned    sz;
            int unsigned    idx;
            int unsigned    i;
            int unsigned    free_cells;
            bit             found;
            n = active_cells();
            sz = eff_size();
            exp_rsp.cell_offset = '0;
            exp_rsp.status = fcpa_pkg::STAT_OK;
            if (req.kind == fcpa_pkg::KIND_ALLOC)
            begin
                found = 1'b0;
                for (i = 0; i < n && !found; i++)
                begin
                    if (free_map[i])
                    begin
                        free_map[i] = 1'b0;
                        exp_rsp.cell_offset = byte_offset(i);
                        found = 1'b1;
                    end
                end
                if (!found)
                    exp_rsp.status = fcpa_pkg::STAT_FULL;
            end
            else
            begin
                idx = req.offset / sz;
                if ((req.offset % sz) != 0 || idx >= n)
                    exp_rsp.status = fcpa_pkg::STAT_BAD;
                else if (free_map[idx])
                    exp_rsp.status = fcpa_pkg::STAT_DOUBLE;
                else
                    free_map[idx] = 1'b1;
            end
            free_cells = 0;
            for (i = 0; i < n; i++)
                if (free_map[i])
                    free_cells++;
            exp_rsp.free_count = free_cells[CNT_W-1:0];
            owed_results.push_back(exp_rsp);
        endfunction

        // compare one result with the oldest expected one
        function void check_result(fcpa_pkg::rsp_t got);
            fcpa_pkg::rsp_t exp_rsp;
            if (owed_results.size() == 0)
            begin
                $error("unexpected result: cell_offset %0d status %0d free_count %0d",
                       got.cell_offset, got.status, got.free_count);
                error_count++;
                return;
            end
            exp_rsp = owed_results.pop_front();
            if (got.cell_offset !== exp_rsp.cell_offset)
            begin
                $error("cell_offset: expected %0d, actual %0d",
                       exp_rsp.cell_offset, got.cell_offset);
                error_count++;
            end
            if (got.status !== exp_rsp.status)
            begin
                $error("status: expected %0d, actual %0d", exp_rsp.status, got.status);
                error_count++;
            end
            if (got.free_count !== exp_rsp.free_count)
            begin
                $error("free_count: expected %0d, actual %0d",
                       exp_rsp.free_count, got.free_count);
                error_count++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    fcpa_pkg::req_t    in_data;
    logic              out_valid;
    logic              out_ready;
    fcpa_pkg::rsp_t    out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [SZ_W-1:0]   cfg_data;

    pool_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             holdoff_left;

    fixed_cell_pool_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // observe every handshake at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (cfg_valid && cfg_ready)
                sb.apply_register(cfg_index, cfg_data);
        end
    end

    // result receiver: random stalls plus an optional long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_left > 0)
            begin
                out_ready <= 1'b0;
                holdoff_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog: stop when no channel moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    // offer one request item and hold it until taken
    task automatic send_request(input fcpa_pkg::req_t req);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // random idle cycles on the request side
    task automatic sender_gap();
        int n;
        n = 0;
        while ($urandom_range(99) < send_idle_pct)
            n++;
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_item(input logic kind, input int offset);
        fcpa_pkg::req_t req;
        req.kind   = kind;
        req.offset = offset[OFF_W-1:0];
        send_request(req);
        sender_gap();
    endtask

    // stop offering and wait for every outstanding result
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.owed_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [SZ_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // reconfigure the pool once it is idle
    task automatic set_pool(input int count, input int size);
        quiesce();
        write_reg(fcpa_pkg::CFG_CELL_COUNT, count[SZ_W-1:0]);
        write_reg(fcpa_pkg::CFG_CELL_SIZE, size[SZ_W-1:0]);
    endtask

    // directed corner cases
    task automatic run_directed();
        // reset geometry: double free, misaligned, out of range, alloc/free
        send_item(fcpa_pkg::KIND_FREE, 0);
        send_item(fcpa_pkg::KIND_FREE, OFFSET_MAX);
        send_item(fcpa_pkg::KIND_FREE, 256);
        send_item(fcpa_pkg::KIND_ALLOC, OFFSET_MAX);
        send_item(fcpa_pkg::KIND_ALLOC, 0);
        send_item(fcpa_pkg::KIND_FREE, 4);
        send_item(fcpa_pkg::KIND_FREE, 4);
        send_item(fcpa_pkg::KIND_ALLOC, 0);
        // two cells, both used: full pool and out-of-range free
        set_pool(2, 4);
        send_item(fcpa_pkg::KIND_ALLOC, 0);
        send_item(fcpa_pkg::KIND_FREE, 8);
        // empty pool
        set_pool(0, 4);
        send_item(fcpa_pkg::KIND_ALLOC, 0);
        send_item(fcpa_pkg::KIND_FREE, 0);
        // oversized count and zero cell size
        set_pool(100, 0);
        send_item(fcpa_pkg::KIND_FREE, 1);
        send_item(fcpa_pkg::KIND_ALLOC, 0);
        send_item(fcpa_pkg::KIND_FREE, 63);
        send_item(fcpa_pkg::KIND_FREE, 64);
        // largest nominal cell size
        set_pool(64, 4096);
        send_item(fcpa_pkg::KIND_ALLOC, 0);
        send_item(fcpa_pkg::KIND_FREE, OFFSET_MAX);
        send_item(fcpa_pkg::KIND_FREE, 8192);
        // cell size beyond its range
        set_pool(64, 8191);
        send_item(fcpa_pkg::KIND_ALLOC, 0);
    endtask

    // random items: fill and drain waves, mostly frees of used cells
    task automatic run_phase(input int count, input int size, input int s_pct,
                             input int r_pct, input int items, input bit hold);
        fcpa_pkg::req_t req;
        int             step;
        int             alloc_pct;
        int             pick;
        int unsigned    n;
        int unsigned    sz;
        int unsigned    i;
        int unsigned    used_cells[$];
        set_pool(count, size);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        if (hold)
            holdoff_left = HOLDOFF_CYCLES;
        for (step = 0; step < items; step++)
        begin
            alloc_pct  = ((step / 60) % 2 == 0) ? 88 : 20;
            req.offset = OFF_W'($urandom_range(OFFSET_MAX));
            if ($urandom_range(99) < alloc_pct)
            begin
                req.kind = fcpa_pkg::KIND_ALLOC;
            end
            else
            begin
                req.kind = fcpa_pkg::KIND_FREE;
                n  = sb.active_cells();
                sz = sb.eff_size();
                used_cells.delete();
                for (i = 0; i < n; i++)
                    if (!sb.free_map[i])
                        used_cells.push_back(i);
                pick = $urandom_range(99);
                if (pick < 75 && used_cells.size() > 0)
                begin
                    i = used_cells[$urandom_range(used_cells.size() - 1)];
                    req.offset = sb.byte_offset(i);
                end
                else if (pick < 87)
                    req.offset = sb.byte_offset($urandom_range(n + 1));
                else if (pick < 94 && sz > 1)
                    req.offset = OFF_W'(sb.byte_offset($urandom_range(n))
                                        + $urandom_range(sz - 1, 1));
            end
            send_request(req);
            sender_gap();
        end
    endtask

    // main sequence
    initial
    begin
        sb = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = fcpa_pkg::CFG_CELL_COUNT;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_left   = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        run_phase(64, 4, 0, 0, 200, 1'b0);
        run_phase(64, 4096, 84, 0, 200, 1'b0);
        run_phase(64, 8191, 0, 84, 200, 1'b0);
        run_phase(16, 1, 35, 35, 200, 1'b0);
        run_phase(127, 0, 0, 0, 150, 1'b0);
        run_phase(1, 4096, 0, 0, 150, 1'b1);
        run_phase(0, 13, 84, 0, 50, 1'b0);
        run_phase(40, 4095, 35, 35, 200, 1'b0);
        run_phase(64, 4, 0, 84, 200, 1'b0);

        quiesce();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.error_count == 0 && sb.owed_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> fixed_cell_pool_allocator.f
rtl/fcpa_pkg.sv
rtl/fixed_cell_pool_allocator.sv
verif/tb_fixed_cell_pool_allocator.sv
